// File: src/set_assoc_fifo_cache_unit_defines.svh
// Assertion macros for the set-associative FIFO cache.
`ifndef SET_ASSOC_FIFO_CACHE_UNIT_DEFINES_SVH
`define SET_ASSOC_FIFO_CACHE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define SAFC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define SAFC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define SAFC_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define SAFC_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// File: src/safc_pkg.sv
// Package: geometry constants and types of the set-associative FIFO cache.
`timescale 1ns / 1ps
package safc_pkg;
   localparam int WORDS_PER_LINE = 4;
   localparam int WAYS           = 2;
   localparam int SETS           = 16;
   localparam int MEM_WORDS      = 2048;
   localparam int ADDR_W   = 13;
   localparam int DATA_W   = 32;
   localparam int OFF_W    = (WORDS_PER_LINE > 1) ? $clog2(WORDS_PER_LINE) : 1;
   localparam int SET_W    = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int MEM_AW   = $clog2(MEM_WORDS);
   localparam int LINE_AW  = $clog2(SETS * WAYS * WORDS_PER_LINE);
   localparam int TAG_W    = 6;
   localparam logic FUNC_READ  = 1'b0;
   localparam logic FUNC_WRITE = 1'b1;

   typedef struct packed {
      logic                      func;
      logic [ADDR_W-1:0]         address;
      logic signed [DATA_W-1:0]  write_data;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0]  main_word;
      logic                      cache_hit;
      logic signed [DATA_W-1:0]  cache_word;
   } rsp_type;
endpackage

// File: src/safc_if.sv
// Valid/ready channel interfaces for request and response items.
`timescale 1ns / 1ps
interface safc_req_if import safc_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface safc_rsp_if import safc_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// File: src/safc_ram.sv
// Generic single-port-write, one-read synchronous RAM with registered read.
`timescale 1ns / 1ps
module safc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata_ff <= mem[raddr];
   end
   assign rdata = rdata_ff;
endmodule

// File: src/set_assoc_fifo_cache_unit.sv
// Top level: sequencer around tag flops, line RAM and main memory RAM.
//
//  Channel  Dir  Handshake             Payload
//  req      in   req_valid/req_ready   func, address, write_data
//  rsp      out  rsp_valid/rsp_ready   main_word, cache_hit, cache_word
//
// One item at a time. A hit or fill runs S_RD, S_LOOK, then S_RSP or S_FILL.
// Eviction writes back way 0 (S_WB_RD/S_WB_WR per word), then moves each later
// line down a way (S_SH_RD/S_SH_WR per word, line RAM single read port).
// Reset clears the valid bits; then a clearing pass over all main memory words
// sets main memory and line RAM to all ones (no item accepted meanwhile).
// A response waits in its output register; a read stalls at its response stage
// until the previous response drains.
`timescale 1ns / 1ps
`include "set_assoc_fifo_cache_unit_defines.svh"
module set_assoc_fifo_cache_unit import safc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   safc_req_if.sink    req,
   safc_rsp_if.source  rsp
);
   localparam int NLINE = SETS * WAYS * WORDS_PER_LINE;
   localparam int CLR_W = MEM_AW + 1;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_RD, S_LOOK, S_WB_RD, S_WB_WR, S_SH_RD, S_SH_WR, S_FILL, S_RSP
   } state_type;

   state_type state_ff;
   logic [CLR_W-1:0]  clr_ff;
   logic              func_ff;
   logic [DATA_W-1:0] data_ff;
   logic [OFF_W-1:0]  off_ff;
   logic [SET_W-1:0]  set_ff;
   logic [TAG_W-1:0]  tag_ff;
   logic [MEM_AW-1:0] word_ff;
   logic [WAY_W-1:0]  way_ff;
   logic [OFF_W-1:0]  k_ff;
   rsp_type           rsp_ff;
   logic              rsp_valid_ff;
   logic [TAG_W-1:0]  tag_q [SETS*WAYS];
   logic              vld_q [SETS*WAYS];

   // address split
   logic [ADDR_W-1:0] a;
   logic [31:0] lineno;
   assign a = req.payload.address;
   assign lineno = 32'(a) / (4 * WORDS_PER_LINE);

   // tag match over the set
   logic hit_c, empty_c;
   logic [WAY_W-1:0] hway_c, eway_c;
   always_comb begin
      hit_c = 1'b0; empty_c = 1'b0; hway_c = '0; eway_c = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (vld_q[int'(set_ff) * WAYS + w] && tag_q[int'(set_ff) * WAYS + w] == tag_ff) begin
            hit_c = 1'b1; hway_c = WAY_W'(w);
         end
         if (!vld_q[int'(set_ff) * WAYS + w]) begin
            empty_c = 1'b1; eway_c = WAY_W'(w);
         end
      end
   end

   // RAM ports
   logic              l_we, m_we;
   logic [LINE_AW-1:0] l_wa, l_ra;
   logic [MEM_AW-1:0]  m_wa, m_ra;
   logic [DATA_W-1:0]  l_wd, m_wd, l_rd, m_rd;

   function automatic logic [LINE_AW-1:0] laddr(logic [SET_W-1:0] s, logic [WAY_W-1:0] w,
                                                logic [OFF_W-1:0] o);
      return LINE_AW'((int'(s) * WAYS + int'(w)) * WORDS_PER_LINE + int'(o));
   endfunction

   logic [MEM_AW-1:0] wb_base;
   assign wb_base = MEM_AW'((int'(tag_q[int'(set_ff) * WAYS]) * SETS + int'(set_ff))
                            * WORDS_PER_LINE);

   always_comb begin
      l_we = 1'b0; m_we = 1'b0;
      l_wa = laddr(set_ff, way_ff, off_ff); l_wd = data_ff;
      l_ra = laddr(set_ff, way_ff, k_ff);
      m_wa = wb_base + MEM_AW'(k_ff); m_wd = l_rd; m_ra = word_ff;
      case (state_ff)
         S_CLEAR: begin
            m_we = 1'b1; m_wa = clr_ff[MEM_AW-1:0]; m_wd = '1;
            l_we = (int'(clr_ff) < NLINE); l_wa = LINE_AW'(clr_ff); l_wd = '1;
         end
         S_LOOK: l_ra = laddr(set_ff, hway_c, off_ff);
         S_RSP: l_ra = laddr(set_ff, way_ff, off_ff);
         S_WB_RD: l_ra = laddr(set_ff, '0, k_ff);
         S_WB_WR: m_we = 1'b1;
         S_SH_RD: l_ra = laddr(set_ff, way_ff + WAY_W'(1), k_ff);
         S_SH_WR: begin
            l_we = 1'b1; l_wa = laddr(set_ff, way_ff, k_ff); l_wd = l_rd;
         end
         S_FILL: l_we = 1'b1;
         default: ;
      endcase
   end

   safc_ram #(.WIDTH(DATA_W), .DEPTH(NLINE)) u_line (
      .clock, .we(l_we), .waddr(l_wa), .wdata(l_wd), .raddr(l_ra), .rdata(l_rd));
   safc_ram #(.WIDTH(DATA_W), .DEPTH(MEM_WORDS)) u_main (
      .clock, .we(m_we), .waddr(m_wa), .wdata(m_wd), .raddr(m_ra), .rdata(m_rd));

   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = rsp_valid_ff;
   assign rsp.payload = rsp_ff;

   // response register loads once the previous item has drained
   logic rsp_load_c;
   assign rsp_load_c = (state_ff == S_RSP || (state_ff == S_FILL && func_ff == FUNC_READ))
                       && (!rsp_valid_ff || rsp.ready);

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR; clr_ff <= '0; rsp_valid_ff <= 1'b0;
         for (int i = 0; i < SETS * WAYS; i++) vld_q[i] <= 1'b0;
      end else begin
         if (rsp_load_c) rsp_valid_ff <= 1'b1;
         else if (rsp.ready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + CLR_W'(1);
               if (int'(clr_ff) == MEM_WORDS - 1) state_ff <= S_IDLE;
            end
            S_IDLE: if (req.valid) begin
               func_ff <= req.payload.func;
               data_ff <= req.payload.write_data;
               word_ff <= MEM_AW'(a >> 2);
               off_ff  <= OFF_W'(32'(a >> 2) % WORDS_PER_LINE);
               set_ff  <= SET_W'(lineno % SETS);
               tag_ff  <= TAG_W'(lineno / SETS);
               state_ff <= S_RD;
            end
            S_RD: state_ff <= S_LOOK;
            S_LOOK: begin
               k_ff <= '0;
               // a read keeps the main word for its response and any fill
               if (func_ff == FUNC_READ) data_ff <= m_rd;
               if (hit_c) begin
                  way_ff <= hway_c;
                  state_ff <= (func_ff == FUNC_READ) ? S_RSP : S_FILL;
               end else if (empty_c) begin
                  way_ff <= eway_c;
                  vld_q[int'(set_ff) * WAYS + int'(eway_c)] <= 1'b1;
                  tag_q[int'(set_ff) * WAYS + int'(eway_c)] <= tag_ff;
                  state_ff <= S_FILL;
               end else begin
                  state_ff <= S_WB_RD;
               end
            end
            S_RSP: if (rsp_load_c) begin
               rsp_ff.main_word <= data_ff;
               rsp_ff.cache_hit <= 1'b1;
               rsp_ff.cache_word <= l_rd;
               state_ff <= S_IDLE;
            end
            S_WB_RD: state_ff <= S_WB_WR;
            S_WB_WR: begin
               way_ff <= '0;
               if (int'(k_ff) == WORDS_PER_LINE - 1) begin
                  k_ff <= '0;
                  state_ff <= (WAYS > 1) ? S_SH_RD : S_FILL;
                  if (WAYS == 1) tag_q[int'(set_ff) * WAYS] <= tag_ff;
               end else begin
                  k_ff <= k_ff + OFF_W'(1);
                  state_ff <= S_WB_RD;
               end
            end
            S_SH_RD: state_ff <= S_SH_WR;
            S_SH_WR: begin
               if (int'(k_ff) == WORDS_PER_LINE - 1) begin
                  k_ff <= '0;
                  tag_q[int'(set_ff) * WAYS + int'(way_ff)] <=
                     tag_q[int'(set_ff) * WAYS + int'(way_ff) + 1];
                  if (int'(way_ff) == WAYS - 2) begin
                     tag_q[int'(set_ff) * WAYS + WAYS - 1] <= tag_ff;
                     way_ff <= WAY_W'(WAYS - 1);
                     state_ff <= S_FILL;
                  end else begin
                     way_ff <= way_ff + WAY_W'(1);
                     state_ff <= S_SH_RD;
                  end
               end else begin
                  k_ff <= k_ff + OFF_W'(1);
                  state_ff <= S_SH_RD;
               end
            end
            S_FILL: begin
               if (func_ff == FUNC_READ) begin
                  if (rsp_load_c) begin
                     rsp_ff.main_word <= data_ff;
                     rsp_ff.cache_hit <= 1'b0;
                     rsp_ff.cache_word <= '0;
                     state_ff <= S_IDLE;
                  end
               end else state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `SAFC_ASSERT_IMPL(a_ready_idle, clock, reset, req.ready, state_ff == S_IDLE && !reset, "ready outside idle")
   `SAFC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp.valid && !rsp.ready, rsp.valid && $stable(rsp.payload), "rsp dropped")
   `SAFC_ASSERT_IMPL(a_miss_zero, clock, reset, rsp.valid && !rsp.payload.cache_hit, rsp.payload.cache_word == '0, "miss word nonzero")
endmodule
